/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// No dependencies; take in with a plain include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define DMC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define DMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/dmc_pkg.sv */
// Shared types and constants of the direct-mapped data cache.
// No dependencies; the other files but assert_macros.svh use it by scoped names.
package dmc_pkg;

    localparam int MAX_LINES_DEF = 256;
    localparam int ADDR_BITS_DEF = 16;
    localparam int ADDR_W        = 16;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = 9;
    localparam int LIDX_W        = 8;
    localparam logic [CNT_W-1:0] LINE_COUNT_RST = 9'd256;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [ADDR_W-1:0]        address;
        logic signed [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic [LIDX_W-1:0]        line_index;
        logic signed [DATA_W-1:0] read_data;
    } rsp_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOOK
    } state_t;

endpackage

/* rtl/core/dmc_rem.sv */
// Serial remainder unit: address modulo line count, one address bit per cycle.
// Depends on dmc_pkg for the divisor width.
module dmc_rem #(
    parameter int TAG_W = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [TAG_W-1:0]          dividend,
    input  logic [dmc_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [dmc_pkg::CNT_W-1:0] remainder
);
    localparam int STEP_W = $clog2(TAG_W + 1);

    logic [TAG_W-1:0]          dvd_reg, dvd_next;
    logic [dmc_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]         cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [dmc_pkg::CNT_W:0]   trial;

    always_comb begin
        trial     = {rem_reg, dvd_reg[TAG_W-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = STEP_W'(TAG_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            // restoring step: shift in next bit, subtract when it fits
            if (trial >= {1'b0, divisor}) begin
                rem_next = dmc_pkg::CNT_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = dmc_pkg::CNT_W'(trial);
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/dmc_store.sv */
// Line storage: tag and data memories with registered read, valid bits in flops.
// Depends on dmc_pkg for the data width and the control struct.
module dmc_store #(
    parameter int MAX_LINES = 256,
    parameter int TAG_W     = 16,
    parameter int IDX_W     = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            invalidate,
    input  dmc_pkg::mem_ctl_t               ctl,
    input  logic [IDX_W-1:0]                idx,
    input  logic [TAG_W-1:0]                wr_tag,
    input  logic signed [dmc_pkg::DATA_W-1:0] wr_data,
    output logic                            rd_valid,
    output logic [TAG_W-1:0]                rd_tag,
    output logic signed [dmc_pkg::DATA_W-1:0] rd_data
);
    logic [TAG_W-1:0]                  tag_mem  [MAX_LINES];
    logic signed [dmc_pkg::DATA_W-1:0] data_mem [MAX_LINES];
    logic [MAX_LINES-1:0]              valid_reg;
    logic                              rd_valid_reg;
    logic [TAG_W-1:0]                  rd_tag_reg;
    logic signed [dmc_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            tag_mem[idx]  <= wr_tag;
            data_mem[idx] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_tag_reg  <= tag_mem[idx];
            rd_data_reg <= data_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || invalidate) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.wr_en) begin
                valid_reg[idx] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= valid_reg[idx];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_tag   = rd_tag_reg;
    assign rd_data  = rd_data_reg;

endmodule

/* rtl/core/direct_mapped_data_cache.sv */
// Direct-mapped data cache, one request at a time.
// Each request runs through the serial remainder, a registered line read and the
// line compare/update; the next request is taken only once the sequencer is idle.
// Reset: synchronous active-low; line count returns to 256, all lines invalid.
// A line count write invalidates every line in the same cycle.
module direct_mapped_data_cache #(
    parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF,
    parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  dmc_pkg::req_t             s_data,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output dmc_pkg::rsp_t             m_data,
    // line count register
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dmc_pkg::CNT_W-1:0] cfg_data
);
    // Only the low ADDR_BITS of the 16-bit address take part; the tag is that part.
    localparam int TAG_W = (ADDR_BITS < dmc_pkg::ADDR_W) ? ADDR_BITS : dmc_pkg::ADDR_W;
    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    dmc_pkg::state_t   state_reg, state_next;
    dmc_pkg::req_t     req_reg;
    dmc_pkg::rsp_t     out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [dmc_pkg::CNT_W-1:0] line_count_reg;
    logic [dmc_pkg::CNT_W-1:0] eff_lines;
    dmc_pkg::mem_ctl_t mem_ctl;
    logic              cfg_wr;
    logic              req_take;
    logic              out_free;
    logic              rem_done;
    logic [dmc_pkg::CNT_W-1:0] rem;
    logic              rd_valid;
    logic [TAG_W-1:0]  rd_tag;
    logic signed [dmc_pkg::DATA_W-1:0] rd_data;
    logic              is_hit;

    // Always ready, unchecked: host writes must come only while the cache is idle.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= dmc_pkg::LINE_COUNT_RST;
        end else if (cfg_wr) begin
            line_count_reg <= cfg_data;
        end
    end

    // Clamp the divisor: zero acts as one line, anything beyond the array as the array.
    always_comb begin
        if (line_count_reg == '0) begin
            eff_lines = dmc_pkg::CNT_W'(1);
        end else if (32'(line_count_reg) > 32'(MAX_LINES)) begin
            eff_lines = dmc_pkg::CNT_W'(MAX_LINES);
        end else begin
            eff_lines = line_count_reg;
        end
    end

    dmc_rem #(
        .TAG_W (TAG_W)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (req_take),
        .dividend  (s_data.address[TAG_W-1:0]),
        .divisor   (eff_lines),
        .done      (rem_done),
        .remainder (rem)
    );

    dmc_store #(
        .MAX_LINES (MAX_LINES),
        .TAG_W     (TAG_W),
        .IDX_W     (IDX_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .invalidate (cfg_wr),
        .ctl        (mem_ctl),
        .idx        (IDX_W'(rem)),
        .wr_tag     (req_reg.address[TAG_W-1:0]),
        .wr_data    (req_reg.write_data),
        .rd_valid   (rd_valid),
        .rd_tag     (rd_tag),
        .rd_data    (rd_data)
    );

    // A lookup hits on a valid line whose tag matches the low TAG_W bits of the address.
    assign is_hit = (req_reg.command == dmc_pkg::CMD_LOOKUP) && rd_valid
                    && (rd_tag == req_reg.address[TAG_W-1:0]);

    // The result register frees up in the cycle its request is taken downstream.
    assign out_free = !out_valid_reg || m_ready;

    // Sequencer: idle -> remainder steps -> line compare/update.
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        req_take       = 1'b0;
        mem_ctl        = '0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            dmc_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                req_take = s_valid;
                if (s_valid) begin
                    state_next = dmc_pkg::ST_DIV;
                end
            end
            dmc_pkg::ST_DIV: begin
                // read the mapped line as soon as the index settles
                if (rem_done) begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = dmc_pkg::ST_LOOK;
                end
            end
            dmc_pkg::ST_LOOK: begin
                // hold here until the result register can take the answer
                if (out_free) begin
                    mem_ctl.wr_en       = (req_reg.command == dmc_pkg::CMD_WRITE);
                    out_next.hit        = is_hit;
                    out_next.line_index = dmc_pkg::LIDX_W'(rem);
                    out_next.read_data  = is_hit ? rd_data : '0;
                    out_valid_next      = 1'b1;
                    state_next          = dmc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dmc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
        if (req_take) begin
            req_reg <= s_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/core/dmc_checker.sv */
// Port-level checks of the direct-mapped data cache, bound to the top level.
// Depends on dmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmc_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input dmc_pkg::rsp_t m_data
);
    // a stalled result keeps its contents
    `DMC_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    // no result survives reset
    `DMC_ASSERT_ALWAYS(a_rst_clear, aclk, !aresetn |=> !m_valid, "result valid after reset")
    // a taken request occupies the cache for at least the next cycle
    `DMC_ASSERT(a_busy_after_take, aclk, aresetn, s_valid && s_ready |=> !s_ready, "request taken while busy")
    // a miss or a write never returns data
    `DMC_ASSERT(a_miss_zero, aclk, aresetn, m_valid && !m_data.hit |-> m_data.read_data == '0, "miss carries data")

endmodule

bind direct_mapped_data_cache dmc_checker u_dmc_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for direct_mapped_data_cache: a shadow cache predicts every result.
// Depends on dmc_pkg (request/result structs, command codes, widths) and the cache RTL.
module tb;

    // Cycle budget: 622 requests, each in the worst case with the full request-to-result
    // latency, a long sender gap and a long result stall, plus config drains.
    localparam int RUN_LIMIT  = 400000;
    // Settle time after the last result, derived from the request-to-result latency.
    localparam int TAIL_WAIT  = 2 * (dmc_pkg::ADDR_W + 2) + 4;
    localparam int MAX_PRINTS = 40;

    typedef enum logic [1:0] {
        OP_REQ,
        OP_CFG,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t                  kind;
        dmc_pkg::req_t             req;
        logic [dmc_pkg::CNT_W-1:0] count;
    } stim_op_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    dmc_pkg::req_t             s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    dmc_pkg::rsp_t             m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [dmc_pkg::CNT_W-1:0] cfg_data  = '0;

    // Pending stimulus (requests, line count writes, drain points) and the
    // results still owed by the cache, oldest first.
    stim_op_t      stim_q[$];
    dmc_pkg::rsp_t rsp_expected_q[$];

    // Shadow copy of the cache contents and its line count register.
    logic [dmc_pkg::CNT_W-1:0]  shadow_count = dmc_pkg::LINE_COUNT_RST;
    logic                       shadow_valid [dmc_pkg::MAX_LINES_DEF] = '{default: 1'b0};
    logic [dmc_pkg::ADDR_W-1:0] shadow_tag   [dmc_pkg::MAX_LINES_DEF];
    logic [dmc_pkg::DATA_W-1:0] shadow_data  [dmc_pkg::MAX_LINES_DEF];

    int mismatch_count = 0;
    int rsp_seen       = 0;
    int cycle_count    = 0;
    int send_gap       = 0;
    int send_quiet     = 0;
    int stall_left     = 0;
    int stall_quiet    = 0;

    direct_mapped_data_cache dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Clamp the raw register value the way the cache does: 0 acts as one line,
    // anything past the table size acts as the full table.
    function automatic int unsigned mapped_lines(logic [dmc_pkg::CNT_W-1:0] raw);
        int unsigned n;
        n = 32'(raw);
        if (n == 0) n = 1;
        if (n > dmc_pkg::MAX_LINES_DEF) n = dmc_pkg::MAX_LINES_DEF;
        return n;
    endfunction

    // Apply one request to the shadow cache and return the result it must produce.
    function automatic dmc_pkg::rsp_t access_shadow_cache(dmc_pkg::req_t r);
        dmc_pkg::rsp_t rsp;
        int unsigned   line;
        line           = 32'(r.address) % mapped_lines(shadow_count);
        rsp.hit        = 1'b0;
        rsp.line_index = line[dmc_pkg::LIDX_W-1:0];
        rsp.read_data  = '0;
        if (r.command == dmc_pkg::CMD_WRITE) begin
            shadow_valid[line] = 1'b1;
            shadow_tag[line]   = r.address;
            shadow_data[line]  = r.write_data;
        end else if (shadow_valid[line] && shadow_tag[line] == r.address) begin
            rsp.hit       = 1'b1;
            rsp.read_data = shadow_data[line];
        end
        return rsp;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one; once in a
    // while enter a quiet stretch with no gaps at all.
    function automatic int pick_gap(inout int quiet_left);
        int r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if (r < 4) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [dmc_pkg::DATA_W-1:0] got,
                                   logic [dmc_pkg::DATA_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] result %0d: %s got %h expected %h",
                     $time, rsp_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic push_req(logic cmd, logic [dmc_pkg::ADDR_W-1:0] addr,
                            logic [dmc_pkg::DATA_W-1:0] wdata);
        stim_op_t op;
        op.kind             = OP_REQ;
        op.req.command      = cmd;
        op.req.address      = addr;
        op.req.write_data   = wdata;
        op.count            = '0;
        stim_q.push_back(op);
    endtask

    task automatic push_cfg(logic [dmc_pkg::CNT_W-1:0] value);
        stim_op_t op;
        op.kind  = OP_CFG;
        op.req   = '0;
        op.count = value;
        stim_q.push_back(op);
    endtask

    task automatic push_drain();
        stim_op_t op;
        op.kind  = OP_DRAIN;
        op.req   = '0;
        op.count = '0;
        stim_q.push_back(op);
    endtask

    // Request and config driver. Hold valid and payload until the handshake;
    // advance the shadow cache at the very edge the request is taken.
    always @(posedge aclk) begin : drive
        logic     req_up;
        logic     cfg_up;
        stim_op_t op;
        req_up = s_valid;
        cfg_up = cfg_valid;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rsp_expected_q.push_back(access_shadow_cache(s_data));
                req_up = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                // A line count write remaps every address: drop all lines.
                shadow_count = cfg_data;
                foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
                cfg_up = 1'b0;
            end
            if (!req_up && !cfg_up) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (stim_q.size() != 0) begin
                    op = stim_q[0];
                    unique case (op.kind)
                        OP_REQ: begin
                            s_data <= op.req;
                            req_up = 1'b1;
                            void'(stim_q.pop_front());
                            send_gap = pick_gap(send_quiet);
                        end
                        OP_CFG: begin
                            // Write the register only once every owed result is back.
                            if (rsp_expected_q.size() == 0) begin
                                cfg_data <= op.count;
                                cfg_up = 1'b1;
                                void'(stim_q.pop_front());
                                send_gap = pick_gap(send_quiet);
                            end
                        end
                        OP_DRAIN: begin
                            if (rsp_expected_q.size() == 0) void'(stim_q.pop_front());
                        end
                        default: void'(stim_q.pop_front());
                    endcase
                end
            end
        end
        s_valid   <= req_up;
        cfg_valid <= cfg_up;
    end

    // Result monitor: compare each accepted result with the oldest prediction,
    // then pick the ready level for the next cycle.
    always @(posedge aclk) begin : watch
        dmc_pkg::rsp_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (rsp_expected_q.size() == 0) begin
                    report_mismatch("result with no request outstanding, read_data",
                                    m_data.read_data, '0);
                end else begin
                    want = rsp_expected_q.pop_front();
                    if (m_data.hit !== want.hit)
                        report_mismatch("hit", dmc_pkg::DATA_W'(m_data.hit),
                                        dmc_pkg::DATA_W'(want.hit));
                    if (m_data.line_index !== want.line_index)
                        report_mismatch("line_index", dmc_pkg::DATA_W'(m_data.line_index),
                                        dmc_pkg::DATA_W'(want.line_index));
                    if (m_data.read_data !== want.read_data)
                        report_mismatch("read_data", m_data.read_data, want.read_data);
                end
                rsp_seen++;
                stall_left = pick_gap(stall_quiet);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int                         plan [12];
        logic [dmc_pkg::ADDR_W-1:0] history [$];
        logic [dmc_pkg::ADDR_W-1:0] addr;
        int unsigned                n;
        int                         r;
        int                         k;

        aresetn   = 1'b0;

        // Directed part at the reset line count of 256.
        push_req(dmc_pkg::CMD_WRITE,  16'h0000, 32'h7FFF_FFFF);
        push_req(dmc_pkg::CMD_LOOKUP, 16'h0000, 32'h0000_0000);  // hit
        push_req(dmc_pkg::CMD_LOOKUP, 16'h0100, 32'h1234_5678);  // same line, other tag: miss
        push_req(dmc_pkg::CMD_LOOKUP, 16'h00FF, 32'hFFFF_FFFF);  // line never written: miss
        push_req(dmc_pkg::CMD_WRITE,  16'hFFFF, 32'h8000_0000);  // top address, most negative
        push_req(dmc_pkg::CMD_LOOKUP, 16'hFFFF, 32'h0000_0000);
        push_req(dmc_pkg::CMD_WRITE,  16'h0100, 32'hFFFF_FFFF);  // evict address 0 from line 0
        push_req(dmc_pkg::CMD_LOOKUP, 16'h0000, 32'h0000_0000);
        push_req(dmc_pkg::CMD_LOOKUP, 16'h0100, 32'h0000_0000);
        push_req(dmc_pkg::CMD_WRITE,  16'h5555, 32'hAAAA_AAAA);
        push_req(dmc_pkg::CMD_LOOKUP, 16'h5555, 32'h5555_5555);
        push_req(dmc_pkg::CMD_WRITE,  16'hAAAA, 32'h5555_5555);
        push_req(dmc_pkg::CMD_LOOKUP, 16'hAAAA, 32'hAAAA_AAAA);
        // Zero lines acts as one line; the write also flushes everything.
        push_cfg(9'd0);
        push_req(dmc_pkg::CMD_LOOKUP, 16'h0100, 32'h0000_0000);  // flushed: miss
        push_req(dmc_pkg::CMD_WRITE,  16'h1234, 32'h0000_0000);
        push_req(dmc_pkg::CMD_LOOKUP, 16'h1234, 32'h0000_0000);
        push_req(dmc_pkg::CMD_LOOKUP, 16'h4321, 32'h0000_0000);
        // Above the table size acts as the full table.
        push_cfg(9'd511);
        push_req(dmc_pkg::CMD_LOOKUP, 16'h1234, 32'h0000_0000);
        push_req(dmc_pkg::CMD_WRITE,  16'hFFFF, 32'h0000_0001);
        push_req(dmc_pkg::CMD_LOOKUP, 16'hFFFF, 32'h0000_0000);
        push_cfg(9'd1);
        push_req(dmc_pkg::CMD_WRITE,  16'h8000, 32'hDEAD_BEEF);
        push_req(dmc_pkg::CMD_LOOKUP, 16'h8000, 32'h0000_0000);

        // Random part: one line count per phase, mostly well-formed write then
        // read-back traffic, plus conflicting aliases and stray lookups.
        plan = '{2, 7, 256, 13, 100, 300, 255, 1, 64, 0, 511, 0};
        plan[11] = $urandom_range(1, 256);
        foreach (plan[p]) begin
            push_cfg(plan[p][dmc_pkg::CNT_W-1:0]);
            n = mapped_lines(plan[p][dmc_pkg::CNT_W-1:0]);
            history.delete();
            for (int i = 0; i < 50; i++) begin
                if (p == 4 && i == 25) push_drain();
                r = $urandom_range(0, 99);
                if (r < 35 || history.size() == 0) begin
                    if ($urandom_range(0, 9) < 6)
                        addr = dmc_pkg::ADDR_W'($urandom_range(0, 4 * n - 1));
                    else
                        addr = dmc_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
                    history.push_back(addr);
                    push_req(dmc_pkg::CMD_WRITE, addr, $urandom);
                end else if (r < 70) begin
                    k = $urandom_range(0, history.size() - 1);
                    push_req(dmc_pkg::CMD_LOOKUP, history[k], $urandom);
                end else if (r < 85) begin
                    k = $urandom_range(0, history.size() - 1);
                    addr = dmc_pkg::ADDR_W'(32'(history[k]) + n * $urandom_range(1, 3));
                    push_req(dmc_pkg::CMD_LOOKUP, addr, $urandom);
                end else begin
                    push_req(dmc_pkg::CMD_LOOKUP,
                             dmc_pkg::ADDR_W'($urandom_range(0, 16'hFFFF)), $urandom);
                end
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to go out and every result to come back.
        while (stim_q.size() != 0 || s_valid || cfg_valid || rsp_expected_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/dmc_pkg.sv
rtl/core/dmc_rem.sv
rtl/core/dmc_store.sv
rtl/core/direct_mapped_data_cache.sv
rtl/core/dmc_checker.sv
dv/tb.sv
